FILE: rtl/rme_pkg.sv
`timescale 1ns / 1ps
package rme_pkg;

  localparam int DATA_W     = 16;
  localparam int THR_W      = 15;
  localparam int SUM_W      = 32;
  localparam int SQRT_STEPS = 16;
  localparam int OPND_W     = 17;
  localparam int CORDIC_W   = 34;
  localparam int ANGLE_W    = 26;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int FRAC_SHIFT = 14;
  localparam int OUT_SHIFT  = 9;

  localparam int ELEM_LAT   = SQRT_STEPS + 2;
  localparam int PIPE_LAT   = ELEM_LAT + 1 + CORDIC_LAT;

  localparam logic signed [ANGLE_W-1:0] DEG_180   = 26'sd11796480;
  localparam logic signed [ANGLE_W-1:0] ROUND_OFS = 26'sd256;
  localparam logic signed [DATA_W-1:0]  DEG_LIMIT = 16'sd23040;

  localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] e00;
    logic signed [DATA_W-1:0] e10;
    logic signed [DATA_W-1:0] e20;
    logic signed [DATA_W-1:0] e21;
    logic signed [DATA_W-1:0] e22;
    logic signed [DATA_W-1:0] e11;
    logic signed [DATA_W-1:0] e12;
  } elems_t;

endpackage

FILE: rtl/rme_isqrt.sv
`timescale 1ns / 1ps
module rme_isqrt import rme_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SUM_W-1:0]  radicand_i,
  output logic [DATA_W-1:0] root_o
);

  logic [SUM_W-1:0] rem_q  [0:SQRT_STEPS-1];
  logic [SUM_W-1:0] root_q [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SUM_W-1:0] Bit = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] rem_in, root_in, trial;

    if (k == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = root_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= (root_in >> 1) + Bit;
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1][DATA_W-1:0];

endmodule

FILE: rtl/rme_cordic.sv
`timescale 1ns / 1ps
module rme_cordic import rme_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [OPND_W-1:0] y_i,
  input  logic signed [OPND_W-1:0] x_i,
  output logic signed [DATA_W-1:0] angle_o
);

  logic signed [CORDIC_W-1:0] x_q [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_q [0:CORDIC_STEPS];
  logic signed [ANGLE_W-1:0]  z_q [0:CORDIC_STEPS];
  logic                       zero_q [0:CORDIC_STEPS];
  logic signed [DATA_W-1:0]   angle_q;

  logic signed [OPND_W:0]     xs, ys, xn, yn;
  logic signed [ANGLE_W-1:0]  base;
  logic signed [ANGLE_W-1:0]  zsum;
  logic signed [ANGLE_W-OUT_SHIFT-1:0] qang;
  logic signed [DATA_W-1:0]   qsat;

  always_comb begin
    xs = {x_i[OPND_W-1], x_i};
    ys = {y_i[OPND_W-1], y_i};
    if (x_i < 0) begin
      xn   = -xs;
      yn   = -ys;
      base = (y_i >= 0) ? DEG_180 : -DEG_180;
    end else begin
      xn   = xs;
      yn   = ys;
      base = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_W'(xn) <<< FRAC_SHIFT;
      y_q[0]    <= CORDIC_W'(yn) <<< FRAC_SHIFT;
      z_q[0]    <= base;
      zero_q[0] <= (x_i == 0) && (y_i == 0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_TABLE[i];
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_TABLE[i];
        end
      end
    end
  end

  always_comb begin
    zsum = z_q[CORDIC_STEPS] + ROUND_OFS;
    qang = (ANGLE_W-OUT_SHIFT)'(zsum >>> OUT_SHIFT);
    if (qang > (ANGLE_W-OUT_SHIFT)'(DEG_LIMIT)) begin
      qsat = DEG_LIMIT;
    end else if (qang < -(ANGLE_W-OUT_SHIFT)'(DEG_LIMIT)) begin
      qsat = -DEG_LIMIT;
    end else begin
      qsat = DATA_W'(qang);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zero_q[CORDIC_STEPS] ? '0 : qsat;
    end
  end

  assign angle_o = angle_q;

endmodule

FILE: rtl/rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps
// A transaction passes squaring, sum, square root, operand and CORDIC registers.
// Throughput: one transaction per cycle unless stalled; squares, a 16-step square
// root pipeline and three parallel 16-step CORDIC pipelines step once per stage.
// A stall at the output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets the singularity threshold thr_q to 1.
module rotation_matrix_to_euler_top import rme_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [THR_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] elem_00_i,
  input  logic signed [DATA_W-1:0] elem_10_i,
  input  logic signed [DATA_W-1:0] elem_20_i,
  input  logic signed [DATA_W-1:0] elem_21_i,
  input  logic signed [DATA_W-1:0] elem_22_i,
  input  logic signed [DATA_W-1:0] elem_11_i,
  input  logic signed [DATA_W-1:0] elem_12_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] roll_deg_o,
  output logic signed [DATA_W-1:0] pitch_deg_o,
  output logic signed [DATA_W-1:0] yaw_deg_o,
  output logic                     is_singular_o
);

  logic                   en;
  logic [THR_W-1:0]       thr_q;
  logic                   v_q [0:PIPE_LAT-1];
  elems_t                 el_q [0:ELEM_LAT-1];
  logic [SUM_W-2:0]       sq00_q, sq10_q;
  logic [SUM_W-1:0]       sum_q;
  logic [DATA_W-1:0]      sy;
  logic                   sing_d;
  logic                   sing_q [0:CORDIC_LAT];
  logic signed [2*DATA_W-1:0] p00, p10;
  logic signed [OPND_W-1:0] roll_y_q, roll_x_q, pitch_y_q, pitch_x_q, yaw_y_q, yaw_x_q;
  logic signed [DATA_W-1:0] roll_c, pitch_c, yaw_c;
  elems_t                 el_in, el_last;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_LAT; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  assign el_in = '{e00: elem_00_i, e10: elem_10_i, e20: elem_20_i, e21: elem_21_i,
                   e22: elem_22_i, e11: elem_11_i, e12: elem_12_i};
  assign p00 = elem_00_i * elem_00_i;
  assign p10 = elem_10_i * elem_10_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      el_q[0] <= el_in;
      for (int k = 1; k < ELEM_LAT; k++) begin
        el_q[k] <= el_q[k-1];
      end
      sq00_q <= p00[SUM_W-2:0];
      sq10_q <= p10[SUM_W-2:0];
      sum_q  <= SUM_W'(sq00_q) + SUM_W'(sq10_q);
    end
  end

  rme_isqrt u_isqrt (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (sum_q),
    .root_o     (sy)
  );

  assign el_last = el_q[ELEM_LAT-1];
  assign sing_d  = sy < DATA_W'(thr_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_y_q <= -OPND_W'(el_last.e20);
      pitch_x_q <= OPND_W'({1'b0, sy});
      if (sing_d) begin
        roll_y_q <= -OPND_W'(el_last.e12);
        roll_x_q <= OPND_W'(el_last.e11);
      end else begin
        roll_y_q <= OPND_W'(el_last.e21);
        roll_x_q <= OPND_W'(el_last.e22);
      end
      yaw_y_q   <= OPND_W'(el_last.e10);
      yaw_x_q   <= OPND_W'(el_last.e00);
      sing_q[0] <= sing_d;
      for (int k = 1; k <= CORDIC_LAT; k++) begin
        sing_q[k] <= sing_q[k-1];
      end
    end
  end

  rme_cordic u_roll (
    .clk_i (clk_i), .en_i (en), .y_i (roll_y_q), .x_i (roll_x_q), .angle_o (roll_c)
  );

  rme_cordic u_pitch (
    .clk_i (clk_i), .en_i (en), .y_i (pitch_y_q), .x_i (pitch_x_q), .angle_o (pitch_c)
  );

  rme_cordic u_yaw (
    .clk_i (clk_i), .en_i (en), .y_i (yaw_y_q), .x_i (yaw_x_q), .angle_o (yaw_c)
  );

  assign out_valid_o   = v_q[PIPE_LAT-1];
  assign is_singular_o = sing_q[CORDIC_LAT];
  assign roll_deg_o    = roll_c;
  assign pitch_deg_o   = pitch_c;
  assign yaw_deg_o     = is_singular_o ? '0 : yaw_c;

  a_yaw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_singular_o) |-> (yaw_deg_o == '0))
    else $error("yaw not zero on singular transaction");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((roll_deg_o <= DEG_LIMIT) && (roll_deg_o >= -DEG_LIMIT)))
    else $error("roll out of range");

  a_thr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (thr_q == '0) |-> !sing_d)
    else $error("singular with zero threshold");

endmodule

FILE: bench/tb_rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler_top;
  import rme_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] r00, r10, r20, r21, r22, r11, r12;
  } matrix_t;

  typedef struct {
    logic signed [DATA_W-1:0] roll, pitch, yaw;
    logic                     sing;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [THR_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DATA_W-1:0] elem_00_i = '0, elem_10_i = '0, elem_20_i = '0, elem_21_i = '0;
  logic signed [DATA_W-1:0] elem_22_i = '0, elem_11_i = '0, elem_12_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] roll_deg_o, pitch_deg_o, yaw_deg_o;
  logic is_singular_o;

  rotation_matrix_to_euler_top dut (.*);

  always #10 clk_i = ~clk_i;

  matrix_t pending_q[$];
  angles_t expected_q[$];
  logic [THR_W-1:0] threshold = THR_W'(1);
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int errors = 0;
  longint cycles = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint root, bit_v;
    root = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n = n - (root + bit_v);
        root = (root >>> 1) + bit_v;
      end else begin
        root = root >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return root;
  endfunction

  function automatic logic signed [DATA_W-1:0] atan2_deg(longint y, longint x);
    longint base, z, q, dx, dy;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      base = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TABLE[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TABLE[i]);
      end
    end
    q = floor_shr(base + z + 256, OUT_SHIFT);
    if (q > 23040) q = 23040;
    if (q < -23040) q = -23040;
    return q[DATA_W-1:0];
  endfunction

  function automatic angles_t euler_of(matrix_t m);
    angles_t a;
    longint sy;
    sy = int_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
    a.sing = sy < longint'(threshold);
    a.pitch = atan2_deg(-longint'(m.r20), sy);
    if (!a.sing) begin
      a.roll = atan2_deg(m.r21, m.r22);
      a.yaw = atan2_deg(m.r10, m.r00);
    end else begin
      a.roll = atan2_deg(-longint'(m.r12), m.r11);
      a.yaw = '0;
    end
    return a;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_i <= 1'b0;
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          matrix_t m;
          m = pending_q.pop_front();
          expected_q.insert(expected_q.size(), euler_of(m));
          {elem_00_i, elem_10_i, elem_20_i} <= {m.r00, m.r10, m.r20};
          {elem_21_i, elem_22_i, elem_11_i, elem_12_i} <= {m.r21, m.r22, m.r11, m.r12};
          in_valid_i <= 1'b1;
        end
      end else if (!in_valid_i && pending_q.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        matrix_t m;
        m = pending_q.pop_front();
        expected_q.insert(expected_q.size(), euler_of(m));
        {elem_00_i, elem_10_i, elem_20_i} <= {m.r00, m.r10, m.r20};
        {elem_21_i, elem_22_i, elem_11_i, elem_12_i} <= {m.r21, m.r22, m.r11, m.r12};
        in_valid_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        angles_t e;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result roll %0d pitch %0d yaw %0d sing %0b", $time,
                   roll_deg_o, pitch_deg_o, yaw_deg_o, is_singular_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (roll_deg_o !== e.roll) begin
            $display("%0t roll expected %0d actual %0d", $time, e.roll, roll_deg_o);
            errors++;
          end
          if (pitch_deg_o !== e.pitch) begin
            $display("%0t pitch expected %0d actual %0d", $time, e.pitch, pitch_deg_o);
            errors++;
          end
          if (yaw_deg_o !== e.yaw) begin
            $display("%0t yaw expected %0d actual %0d", $time, e.yaw, yaw_deg_o);
            errors++;
          end
          if (is_singular_o !== e.sing) begin
            $display("%0t singular expected %0b actual %0b", $time, e.sing, is_singular_o);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_elem();
    int k;
    k = $urandom_range(9);
    if (k == 0) return $signed(16'($urandom));
    if (k == 1) return (($urandom_range(1)) ? 16'sd16384 : -16'sd16384);
    if (k == 2) return $signed(16'($urandom_range(8))) - 16'sd4;
    return $signed(16'($urandom_range(32768))) - 16'sd16384;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.r00 = rand_elem();
    m.r10 = rand_elem();
    m.r20 = rand_elem();
    m.r21 = rand_elem();
    m.r22 = rand_elem();
    m.r11 = rand_elem();
    m.r12 = rand_elem();
    if ($urandom_range(3) == 0) begin
      m.r00 = $signed(16'($urandom_range(64))) - 16'sd32;
      m.r10 = $signed(16'($urandom_range(64))) - 16'sd32;
    end
    return m;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_data_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = v;
  endtask

  initial begin
    logic signed [DATA_W-1:0] corner[6];
    matrix_t m;
    int idle_set[4][2];
    logic [THR_W-1:0] thr_set[5];
    corner = '{16'sd16384, -16'sd16384, 16'sd0, -16'sd32768, 16'sd32767, 16'sd1};
    idle_set = '{'{0, 0}, '{68, 0}, '{0, 68}, '{24, 24}};
    thr_set = '{15'd0, 15'd16384, 15'd32767, 15'd300, 15'd2};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 6; i++) begin
      m.r00 = corner[i]; m.r10 = corner[(i + 1) % 6]; m.r20 = corner[(i + 2) % 6];
      m.r21 = corner[(i + 3) % 6]; m.r22 = corner[(i + 4) % 6];
      m.r11 = corner[(i + 5) % 6]; m.r12 = corner[i];
      pending_q.insert(pending_q.size(), m);
    end
    m = '{default: 16'sd0};
    pending_q.insert(pending_q.size(), m);
    m.r20 = 16'sd16384; m.r11 = -16'sd5; m.r12 = 16'sd7;
    pending_q.insert(pending_q.size(), m);
    m.r20 = -16'sd16384; m.r11 = 16'sd0; m.r12 = 16'sd0;
    pending_q.insert(pending_q.size(), m);
    m = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0};
    pending_q.insert(pending_q.size(), m);
    m = '{-16'sd1, 16'sd0, 16'sd0, -16'sd1, -16'sd1, -16'sd1, 16'sd1};
    pending_q.insert(pending_q.size(), m);
    m = '{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0};
    pending_q.insert(pending_q.size(), m);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_set[p]);
      for (int s = 0; s < 4; s++) begin
        send_idle_pct = idle_set[s][0];
        recv_stall_pct = idle_set[s][1];
        if (p == 1 && s == 0) hold_off = 200;
        for (int k = 0; k < 95; k++) pending_q.insert(pending_q.size(), rand_matrix());
        drain();
      end
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
